### hw/rtl/qrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Widths, case codes, pipeline stage types and the per-stage step functions
// of the square root and divide pipelines.
// ----------------------------------------------------------------------------
package qrs_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int MAG_W      = DATA_WIDTH;
   localparam int PROD_W     = 2 * DATA_WIDTH;
   localparam int D_W        = 2 * DATA_WIDTH + 2;
   localparam int ROOT_W     = DATA_WIDTH + 1;
   localparam int SQ_N       = D_W / 2;
   localparam int SRW        = ROOT_W + 2;
   localparam int NUM_W      = DATA_WIDTH + 2;
   localparam int DEN_W      = DATA_WIDTH + 1;
   localparam int REM_W      = DEN_W + 1;
   localparam int N_W        = NUM_W + FRAC_BITS;
   localparam int Q_N        = DATA_WIDTH;
   localparam int CMP_W      = N_W + DATA_WIDTH + DEN_W;

   typedef enum logic [2:0] {
      CASE_NONE,
      CASE_LINEAR,
      CASE_TWO,
      CASE_DOUBLE,
      CASE_COMPLEX
   } case_type;

   typedef struct packed {
      case_type           code;
      logic               sa;
      logic               nb;
      logic [MAG_W-1:0]   mb;
      logic [DEN_W-1:0]   den;
      logic               lneg;
      logic [MAG_W-1:0]   mc;
   } info_type;

   typedef struct packed {
      info_type           info;
      logic [D_W-1:0]     dsh;
      logic [SRW-1:0]     rem;
      logic [ROOT_W-1:0]  root;
   } sq_type;

   typedef struct packed {
      logic [REM_W-1:0]      rem;
      logic [DATA_WIDTH-1:0] nsh;
      logic [DATA_WIDTH-1:0] quo;
      logic [DEN_W-1:0]      den;
      logic                  neg;
      logic                  ovf;
   } lane_type;

   typedef struct packed {
      case_type code;
      lane_type l1;
      lane_type l2;
   } dv_type;

   typedef struct packed {
      logic             neg;
      logic [NUM_W-1:0] mag;
   } sm_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] val;
      logic                  sat;
   } res_type;

   function automatic logic [MAG_W-1:0] mag_of(input logic [DATA_WIDTH-1:0] raw);
      return raw[DATA_WIDTH-1] ? (~raw + 1'b1) : raw;
   endfunction

   function automatic sq_type sq_step(input sq_type x);
      logic [SRW-1:0] rem_t;
      logic [SRW-1:0] trial;
      sq_type         y;
      rem_t = {x.rem[SRW-3:0], x.dsh[D_W-1 -: 2]};
      trial = {x.root, 2'b01};
      y = x;
      y.dsh = x.dsh << 2;
      if (rem_t >= trial) begin
         y.rem  = rem_t - trial;
         y.root = {x.root[ROOT_W-2:0], 1'b1};
      end else begin
         y.rem  = rem_t;
         y.root = {x.root[ROOT_W-2:0], 1'b0};
      end
      return y;
   endfunction

   function automatic sm_type sm_add(input logic sx, input logic [NUM_W-1:0] mx,
                                     input logic sy, input logic [NUM_W-1:0] my);
      sm_type r;
      if (sx == sy) begin
         r.neg = sx;
         r.mag = mx + my;
      end else if (mx >= my) begin
         r.neg = sx;
         r.mag = mx - my;
      end else begin
         r.neg = sy;
         r.mag = my - mx;
      end
      return r;
   endfunction

   function automatic lane_type lane_init(input logic neg, input logic [NUM_W-1:0] num,
                                          input logic [DEN_W-1:0] den);
      logic [N_W-1:0] n;
      lane_type       y;
      n = N_W'(num) << FRAC_BITS;
      y.rem = REM_W'(n >> DATA_WIDTH);
      y.nsh = n[DATA_WIDTH-1:0];
      y.quo = '0;
      y.den = den;
      y.neg = neg;
      y.ovf = CMP_W'(n) >= (CMP_W'(den) << DATA_WIDTH);
      return y;
   endfunction

   function automatic lane_type div_step(input lane_type x);
      logic [REM_W-1:0] rem_t;
      lane_type         y;
      rem_t = {x.rem[REM_W-2:0], x.nsh[DATA_WIDTH-1]};
      y = x;
      y.nsh = x.nsh << 1;
      if (rem_t >= REM_W'(x.den)) begin
         y.rem = rem_t - REM_W'(x.den);
         y.quo = {x.quo[DATA_WIDTH-2:0], 1'b1};
      end else begin
         y.rem = rem_t;
         y.quo = {x.quo[DATA_WIDTH-2:0], 1'b0};
      end
      return y;
   endfunction

   function automatic res_type lane_final(input lane_type x);
      logic [DATA_WIDTH-1:0] lim;
      logic [DATA_WIDTH-1:0] mag;
      res_type               r;
      lim   = {1'b0, {(DATA_WIDTH-1){1'b1}}} + DATA_WIDTH'(x.neg);
      r.sat = x.ovf || (x.quo > lim);
      mag   = r.sat ? lim : x.quo;
      r.val = x.neg ? (~mag + 1'b1) : mag;
      return r;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/quadratic_root_solver.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quadratic root solver
// Solves a*x^2 + b*x + c = 0 for signed Q16.16 coefficients and returns a
// case code with up to two saturated Q16.16 real roots.
// ----------------------------------------------------------------------------
//  Channel  Ports                                   Direction
//  req      req_valid, req_stall, req_coef_a/b/c    in (stall out)
//  rsp      rsp_valid, rsp_stall, rsp_case_code,    out (stall in)
//           rsp_root_first, rsp_root_second, rsp_saturated
//
// One request is taken per cycle while req_stall is low, and each gives one
// response on rsp. It uses the one-bit-per-stage square root (33 stages)
// and the two parallel one-bit-per-stage dividers (32 stages).
// Reset clears all stage valid bits. A stall on rsp while rsp_valid is high
// holds the whole pipeline and is passed straight to req_stall.
// ----------------------------------------------------------------------------
module quadratic_root_solver (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [qrs_pkg::DATA_WIDTH-1:0]  req_coef_a,
   input  wire logic [qrs_pkg::DATA_WIDTH-1:0]  req_coef_b,
   input  wire logic [qrs_pkg::DATA_WIDTH-1:0]  req_coef_c,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [2:0]                           rsp_case_code,
   output logic [qrs_pkg::DATA_WIDTH-1:0]       rsp_root_first,
   output logic [qrs_pkg::DATA_WIDTH-1:0]       rsp_root_second,
   output logic                                 rsp_saturated
);
   import qrs_pkg::*;

   logic advance;

   logic             s0_valid_ff;
   logic             s0_sa_ff, s0_sb_ff, s0_sc_ff;
   logic [MAG_W-1:0] s0_ma_ff, s0_mb_ff, s0_mc_ff;

   logic              s1_valid_ff;
   logic [PROD_W-1:0] s1_bb_ff, s1_ac_ff;
   logic              s1_acneg_ff;
   logic              s1_sa_ff, s1_sb_ff, s1_sc_ff;
   logic [MAG_W-1:0]  s1_ma_ff, s1_mb_ff, s1_mc_ff;

   logic       s2_valid_ff;
   sq_type     s2_ff, s2_in;

   logic       sq_valid_ff [SQ_N];
   sq_type     sq_ff [SQ_N];

   logic       pr_valid_ff;
   dv_type     pr_ff, pr_in;

   logic       dv_valid_ff [Q_N];
   dv_type     dv_ff [Q_N];

   logic                  rsp_valid_ff;
   case_type              rsp_code_ff, rsp_code_in;
   logic [DATA_WIDTH-1:0] rsp_r1_ff, rsp_r1_in, rsp_r2_ff, rsp_r2_in;
   logic                  rsp_sat_ff, rsp_sat_in;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   always_comb begin
      logic [D_W-1:0] bb;
      logic [D_W-1:0] ac4;
      logic           gt, eq;
      bb  = D_W'(s1_bb_ff);
      ac4 = D_W'(s1_ac_ff) << 2;
      gt  = s1_acneg_ff || (bb > ac4);
      eq  = !s1_acneg_ff && (bb == ac4);
      s2_in = '0;
      if (s1_acneg_ff) begin
         s2_in.dsh = bb + ac4;
      end else if (gt) begin
         s2_in.dsh = bb - ac4;
      end
      if (s1_ma_ff == '0) begin
         s2_in.info.code = (s1_mb_ff != '0) ? CASE_LINEAR : CASE_NONE;
      end else if (gt) begin
         s2_in.info.code = CASE_TWO;
      end else if (eq) begin
         s2_in.info.code = CASE_DOUBLE;
      end else begin
         s2_in.info.code = CASE_COMPLEX;
      end
      s2_in.info.sa   = s1_sa_ff;
      s2_in.info.nb   = !s1_sb_ff && (s1_mb_ff != '0);
      s2_in.info.mb   = s1_mb_ff;
      s2_in.info.den  = (s1_ma_ff == '0) ? DEN_W'(s1_mb_ff) : {s1_ma_ff, 1'b0};
      s2_in.info.lneg = ((!s1_sc_ff) != s1_sb_ff) && (s1_mc_ff != '0);
      s2_in.info.mc   = s1_mc_ff;
   end

   always_comb begin
      sq_type   q;
      sm_type   p1, p2;
      q = sq_ff[SQ_N-1];
      p1 = sm_add(q.info.nb, NUM_W'(q.info.mb), 1'b0, NUM_W'(q.root));
      p2 = sm_add(q.info.nb, NUM_W'(q.info.mb), 1'b1, NUM_W'(q.root));
      pr_in.code = q.info.code;
      if (q.info.code == CASE_LINEAR || q.info.code == CASE_NONE) begin
         pr_in.l1 = lane_init(q.info.lneg, NUM_W'(q.info.mc), q.info.den);
      end else begin
         pr_in.l1 = lane_init((p1.neg != q.info.sa) && (p1.mag != '0), p1.mag, q.info.den);
      end
      pr_in.l2 = lane_init((p2.neg != q.info.sa) && (p2.mag != '0), p2.mag, q.info.den);
   end

   always_comb begin
      res_type r1, r2;
      r1 = lane_final(dv_ff[Q_N-1].l1);
      r2 = lane_final(dv_ff[Q_N-1].l2);
      rsp_code_in = dv_ff[Q_N-1].code;
      rsp_r1_in   = '0;
      rsp_r2_in   = '0;
      rsp_sat_in  = 1'b0;
      case (rsp_code_in)
         CASE_LINEAR, CASE_DOUBLE: begin
            rsp_r1_in  = r1.val;
            rsp_sat_in = r1.sat;
         end
         CASE_TWO: begin
            rsp_r1_in  = r1.val;
            rsp_r2_in  = r2.val;
            rsp_sat_in = r1.sat || r2.sat;
         end
         default: begin
            rsp_r1_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         pr_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SQ_N; i++) begin
            sq_valid_ff[i] <= 1'b0;
         end
         for (int i = 0; i < Q_N; i++) begin
            dv_valid_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         s0_valid_ff    <= req_valid;
         s1_valid_ff    <= s0_valid_ff;
         s2_valid_ff    <= s1_valid_ff;
         sq_valid_ff[0] <= s2_valid_ff;
         for (int i = 1; i < SQ_N; i++) begin
            sq_valid_ff[i] <= sq_valid_ff[i-1];
         end
         pr_valid_ff    <= sq_valid_ff[SQ_N-1];
         dv_valid_ff[0] <= pr_valid_ff;
         for (int i = 1; i < Q_N; i++) begin
            dv_valid_ff[i] <= dv_valid_ff[i-1];
         end
         rsp_valid_ff <= dv_valid_ff[Q_N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_sa_ff <= req_coef_a[DATA_WIDTH-1];
         s0_sb_ff <= req_coef_b[DATA_WIDTH-1];
         s0_sc_ff <= req_coef_c[DATA_WIDTH-1];
         s0_ma_ff <= mag_of(req_coef_a);
         s0_mb_ff <= mag_of(req_coef_b);
         s0_mc_ff <= mag_of(req_coef_c);

         s1_bb_ff    <= s0_mb_ff * s0_mb_ff;
         s1_ac_ff    <= s0_ma_ff * s0_mc_ff;
         s1_acneg_ff <= (s0_sa_ff != s0_sc_ff) && (s0_mc_ff != '0);
         s1_sa_ff    <= s0_sa_ff;
         s1_sb_ff    <= s0_sb_ff;
         s1_sc_ff    <= s0_sc_ff;
         s1_ma_ff    <= s0_ma_ff;
         s1_mb_ff    <= s0_mb_ff;
         s1_mc_ff    <= s0_mc_ff;

         s2_ff    <= s2_in;
         sq_ff[0] <= sq_step(s2_ff);
         for (int i = 1; i < SQ_N; i++) begin
            sq_ff[i] <= sq_step(sq_ff[i-1]);
         end

         pr_ff         <= pr_in;
         dv_ff[0].code <= pr_ff.code;
         dv_ff[0].l1   <= div_step(pr_ff.l1);
         dv_ff[0].l2   <= div_step(pr_ff.l2);
         for (int i = 1; i < Q_N; i++) begin
            dv_ff[i].code <= dv_ff[i-1].code;
            dv_ff[i].l1   <= div_step(dv_ff[i-1].l1);
            dv_ff[i].l2   <= div_step(dv_ff[i-1].l2);
         end

         rsp_code_ff <= rsp_code_in;
         rsp_r1_ff   <= rsp_r1_in;
         rsp_r2_ff   <= rsp_r2_in;
         rsp_sat_ff  <= rsp_sat_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_case_code   = rsp_code_ff;
   assign rsp_root_first  = rsp_r1_ff;
   assign rsp_root_second = rsp_r2_ff;
   assign rsp_saturated   = rsp_sat_ff;

   a_second_unused: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_case_code != CASE_TWO |-> rsp_root_second == '0)
      else $error("Second root is nonzero without two roots.");

   a_first_unused: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_case_code == CASE_NONE || rsp_case_code == CASE_COMPLEX)
      |-> rsp_root_first == '0 && !rsp_saturated)
      else $error("Root or saturation reported without a root.");

   a_hold_pipe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(pr_ff) && $stable(s2_ff))
      else $error("Pipeline moved while the response was stalled.");

endmodule
`default_nettype wire
